// ===== design/gsa_pkg.sv =====
// Package for the generational slot allocator: types, constants and codes.
`default_nettype none
package gsa_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned IdxW = $clog2(Slots);
  localparam int unsigned CntW = $clog2(Slots + 1);
  localparam logic [7:0] MaxDepth = 8'd255;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0, OP_CLOSE = 3'd1, OP_QUERY = 3'd2,
    OP_ENTER = 3'd3, OP_EXIT = 3'd4, OP_DESTROY = 3'd5,
    OP_BAD6 = 3'd6, OP_BAD7 = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_STALE = 2'd1, ST_FULL = 2'd2, ST_NEST = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  slot_index;
    logic [31:0] handle_generation;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  out_index;
    logic [31:0] out_generation;
    logic [1:0]  status;
    logic        active;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_POP, S_INSERT, S_CLOSE, S_TRIM, S_FLUSH_NOTE, S_FLUSH_FREE,
    S_DALL_USED, S_DALL_PEND, S_FINAL
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;        // latch the input item
    logic pop;         // pop one free stack entry, test it
    logic do_insert;   // claim slot (found or append)
    logic do_close;    // apply close of live handle
    logic trim_step;   // drop one trailing unused slot
    logic note_pend;   // emit notice for pending entry at walk pointer
    logic free_pend;   // push pending entry at walk pointer if eligible
    logic note_used;   // emit notice for used slot at walk pointer if used
    logic walk_reset;  // zero the walk pointer
    logic dall_clear;  // final destroy-all clearing
    logic exit_step;   // depth update for guard exit
    logic enter_step;  // depth update for guard enter
    logic pend_clear;  // clear pending list after flush
    logic emit_final;  // emit the final status item
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [2:0] op;
    logic       depth_zero;
    logic       depth_one;
    logic       depth_max;
    logic       free_empty;
    logic       pop_hit;
    logic       live;
    logic       trim_done;
    logic       walk_pend_end;
    logic       walk_slot_end;
  } stat_t;
endpackage
`default_nettype wire

// ===== design/gsa_datapath.sv =====
// Datapath of the slot allocator: slot table, stacks, counters and result register.
`default_nettype none
module gsa_datapath
  import gsa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  item_i,
  input  wire cmd_t      cmd_i,
  output stat_t          stat_o,
  output logic           valid_o,
  output out_item_t      result_o
);
  logic [Slots-1:0]  used_q, used_d;
  logic [31:0]       gen_q [Slots];
  logic [31:0]       gctr_q, gctr_d;
  logic [CntW-1:0]   tlen_q, tlen_d;
  logic [IdxW-1:0]   free_stk_q [Slots];
  logic [CntW-1:0]   fcnt_q, fcnt_d;
  logic [IdxW-1:0]   pend_q [Slots];
  logic [CntW-1:0]   pcnt_q, pcnt_d;
  logic [7:0]        depth_q, depth_d;
  logic [CntW-1:0]   walk_q, walk_d;
  in_item_t          it_q;
  logic              hit_q, hit_d;
  logic [IdxW-1:0]   hslot_q, hslot_d;
  logic [1:0]        fstat_q, fstat_d;
  logic              fact_q, fact_d;
  logic [IdxW-1:0]   fidx_q, fidx_d;
  logic [31:0]       fgen_q, fgen_d;
  logic              valid_d;
  out_item_t         res_d;

  logic [31:0]     gnext;
  logic [IdxW-1:0] top, wslot, pslot;
  logic [IdxW-1:0] tlast;
  logic            live, push_ok;

  assign gnext = (gctr_q == 32'hFFFF_FFFF) ? 32'd1 : gctr_q + 32'd1;
  assign top   = free_stk_q[IdxW'(fcnt_q - CntW'(1))];
  assign wslot = walk_q[IdxW-1:0];
  assign pslot = pend_q[wslot];
  assign tlast = IdxW'(tlen_q - CntW'(1));
  assign live  = ({1'b0, it_q.slot_index} < CntW'(tlen_q)) &&
                 used_q[it_q.slot_index] && (gen_q[it_q.slot_index] == it_q.handle_generation);
  assign push_ok = fcnt_q < CntW'(Slots);

  always_comb begin
    stat_o.op            = it_q.operation;
    stat_o.depth_zero    = depth_q == 8'd0;
    stat_o.depth_one     = depth_q == 8'd1;
    stat_o.depth_max     = depth_q == MaxDepth;
    stat_o.free_empty    = fcnt_q == '0;
    stat_o.pop_hit       = hit_q;
    stat_o.live          = live;
    stat_o.trim_done     = (tlen_q == '0) || used_q[tlast];
    stat_o.walk_pend_end = walk_q >= pcnt_q;
    stat_o.walk_slot_end = walk_q >= tlen_q;
  end

  always_comb begin
    used_d = used_q; gctr_d = gctr_q; tlen_d = tlen_q; fcnt_d = fcnt_q;
    pcnt_d = pcnt_q; depth_d = depth_q; walk_d = walk_q;
    hit_d = hit_q; hslot_d = hslot_q; fstat_d = fstat_q; fact_d = fact_q;
    fidx_d = fidx_q; fgen_d = fgen_q;
    valid_d = 1'b0; res_d = '0;
    if (cmd_i.load) begin
      hit_d = 1'b0; fstat_d = ST_OK; fact_d = 1'b0; fidx_d = '0; fgen_d = '0;
      walk_d = '0;
    end
    if (cmd_i.pop) begin
      fcnt_d = fcnt_q - CntW'(1);
      if (({1'b0, top} < tlen_q) && !used_q[top]) begin
        hit_d = 1'b1; hslot_d = top;
      end
    end
    if (cmd_i.do_insert) begin
      if (hit_q) begin
        used_d[hslot_q] = 1'b1; fidx_d = hslot_q; fgen_d = gctr_q; gctr_d = gnext;
      end else if (tlen_q >= CntW'(Slots)) begin
        fstat_d = ST_FULL;
      end else begin
        used_d[IdxW'(tlen_q)] = 1'b1; fidx_d = IdxW'(tlen_q);
        fgen_d = gctr_q; gctr_d = gnext; tlen_d = tlen_q + CntW'(1);
      end
    end
    if (cmd_i.do_close) begin
      if (!live) begin
        fstat_d = ST_STALE;
      end else begin
        used_d[it_q.slot_index] = 1'b0; gctr_d = gnext;
        if (depth_q != 8'd0) begin
          if (pcnt_q < CntW'(Slots)) pcnt_d = pcnt_q + CntW'(1);
        end else begin
          valid_d = 1'b1; res_d.kind = 1'b1; res_d.out_index = it_q.slot_index;
          if (push_ok) fcnt_d = fcnt_q + CntW'(1);
        end
      end
    end
    if (cmd_i.trim_step) tlen_d = tlen_q - CntW'(1);
    if (cmd_i.note_pend) begin
      valid_d = 1'b1; res_d.kind = 1'b1; res_d.out_index = pslot;
      walk_d = walk_q + CntW'(1);
    end
    if (cmd_i.free_pend) begin
      if (({1'b0, pslot} < tlen_q) && !used_q[pslot] && push_ok)
        fcnt_d = fcnt_q + CntW'(1);
      walk_d = walk_q + CntW'(1);
    end
    if (cmd_i.note_used) begin
      if (used_q[wslot]) begin
        valid_d = 1'b1; res_d.kind = 1'b1; res_d.out_index = wslot;
      end
      walk_d = walk_q + CntW'(1);
    end
    if (cmd_i.walk_reset) walk_d = '0;
    if (cmd_i.pend_clear) pcnt_d = '0;
    if (cmd_i.enter_step) begin
      if (depth_q == MaxDepth) fstat_d = ST_NEST; else depth_d = depth_q + 8'd1;
    end
    if (cmd_i.exit_step) begin
      if (depth_q == 8'd0) fstat_d = ST_NEST; else depth_d = depth_q - 8'd1;
    end
    if (cmd_i.dall_clear) begin
      used_d = '0; tlen_d = '0; fcnt_d = '0; pcnt_d = '0; depth_d = '0;
    end
    if (cmd_i.emit_final) begin
      valid_d = 1'b1;
      res_d.out_index = fidx_q; res_d.out_generation = fgen_q;
      res_d.status = fstat_q; res_d.active = fact_q; res_d.last = 1'b1;
      if (it_q.operation == OP_QUERY) res_d.active = live;
      if (it_q.operation == OP_BAD6 || it_q.operation == OP_BAD7) res_d.status = ST_STALE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0; gctr_q <= 32'd1; tlen_q <= '0; fcnt_q <= '0; pcnt_q <= '0;
      depth_q <= '0; walk_q <= '0; hit_q <= 1'b0; valid_o <= 1'b0;
    end else begin
      used_q <= used_d; gctr_q <= gctr_d; tlen_q <= tlen_d; fcnt_q <= fcnt_d;
      pcnt_q <= pcnt_d; depth_q <= depth_d; walk_q <= walk_d; hit_q <= hit_d;
      valid_o <= valid_d;
    end
  end

  // Slot generations reset to zero; memories of indices need no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) gen_q[i] <= '0;
    end else begin
      if (cmd_i.do_insert && tlen_q < CntW'(Slots) && !hit_q)
        gen_q[IdxW'(tlen_q)] <= gctr_q;
      else if (cmd_i.do_insert && hit_q)
        gen_q[hslot_q] <= gctr_q;
      if (cmd_i.do_close && live) gen_q[it_q.slot_index] <= gctr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= item_i;
    hslot_q <= hslot_d; fstat_q <= fstat_d; fact_q <= fact_d;
    fidx_q <= fidx_d; fgen_q <= fgen_d; result_o <= res_d;
    if (cmd_i.do_close && live && depth_q != 8'd0 && pcnt_q < CntW'(Slots))
      pend_q[IdxW'(pcnt_q)] <= it_q.slot_index;
    if (cmd_i.do_close && live && depth_q == 8'd0 && push_ok)
      free_stk_q[IdxW'(fcnt_q)] <= it_q.slot_index;
    if (cmd_i.free_pend && ({1'b0, pslot} < tlen_q) && !used_q[pslot] && push_ok)
      free_stk_q[IdxW'(fcnt_q)] <= pslot;
  end
endmodule
`default_nettype wire

// ===== design/gsa_control.sv =====
// Controller state machine of the slot allocator.
`default_nettype none
module gsa_control
  import gsa_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire stat_t stat_i,
  output logic       busy_o,
  output cmd_t       cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = state_q != S_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = S_POP;
        end
      end
      S_POP: begin
        unique case (op_e'(stat_i.op))
          OP_INSERT: state_d = stat_i.depth_zero ? S_INSERT : S_INSERT;
          OP_CLOSE:  state_d = S_CLOSE;
          OP_ENTER: begin cmd_o.enter_step = 1'b1; state_d = S_FINAL; end
          OP_EXIT: begin
            cmd_o.exit_step = 1'b1;
            state_d = stat_i.depth_one ? S_FLUSH_NOTE : S_FINAL;
          end
          OP_DESTROY: state_d = S_DALL_USED;
          default: state_d = S_FINAL;
        endcase
        if (op_e'(stat_i.op) == OP_INSERT && stat_i.depth_zero && !stat_i.free_empty) begin
          cmd_o.pop = 1'b1;
          state_d = S_INSERT;
        end
      end
      S_INSERT: begin
        // Keep popping until a usable entry or the stack runs dry; only at depth zero.
        if (stat_i.depth_zero && !stat_i.pop_hit && !stat_i.free_empty) begin
          cmd_o.pop = 1'b1;
        end else begin
          cmd_o.do_insert = 1'b1;
          state_d = S_FINAL;
        end
      end
      S_CLOSE: begin
        cmd_o.do_close = 1'b1;
        state_d = (stat_i.live && stat_i.depth_zero) ? S_TRIM : S_FINAL;
      end
      S_TRIM: begin
        if (stat_i.trim_done) state_d = S_FINAL;
        else cmd_o.trim_step = 1'b1;
      end
      S_FLUSH_NOTE: begin
        if (stat_i.walk_pend_end) begin
          cmd_o.walk_reset = 1'b1;
          state_d = S_FLUSH_FREE;
        end else cmd_o.note_pend = 1'b1;
      end
      S_FLUSH_FREE: begin
        if (stat_i.walk_pend_end) begin
          cmd_o.pend_clear = 1'b1;
          state_d = S_TRIM;
        end else cmd_o.free_pend = 1'b1;
      end
      S_DALL_USED: begin
        if (stat_i.walk_slot_end) begin
          cmd_o.walk_reset = 1'b1;
          state_d = S_DALL_PEND;
        end else cmd_o.note_used = 1'b1;
      end
      S_DALL_PEND: begin
        if (stat_i.walk_pend_end) begin
          cmd_o.dall_clear = 1'b1;
          state_d = S_FINAL;
        end else cmd_o.note_pend = 1'b1;
      end
      S_FINAL: begin
        cmd_o.emit_final = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/generational_slot_allocator.sv =====
// Top level of the generational slot allocator.
`default_nettype none
// A handle table of 16 slots, each holding a used flag and a 32-bit generation.
// An item is taken on a rising edge with start high and busy low; the item
// carries an operation (insert, close, query, guard enter, guard exit, destroy
// all), a slot index and a handle generation.
// Every item produces zero or more destroy notices followed by one final status
// item, each shown for a single cycle with valid_o high; the final one has last
// set. The receiver cannot stall, so results are simply taken as they appear.
// Steps per item: query, guard enter, guard exit that stays above depth zero
// and the undefined operations go straight to the final item. Insert at depth
// zero first pops free stack entries until one is usable or the stack runs
// dry. Close of a stale handle or above depth zero goes straight to the final
// item; at depth zero it then trims the trailing unused slots. Destroy all
// walks the table and then the pending list, one entry per cycle. Guard exit
// to depth zero walks the pending list twice and then trims; that walk sets
// the worst case.
// busy falls in the cycle in which the final item is shown, so the next item
// can be taken on the same edge that takes that final item.
// After reset the table is empty, the generation counter is one and the depth
// is zero; the block is ready at once, with no clearing pass.
module generational_slot_allocator
  import gsa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t item_i,
  output logic          valid_o,
  output out_item_t     result_o
);
  cmd_t  cmd;
  stat_t stat;

  // Controller sequences each item; datapath holds all table state.
  gsa_control u_control (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  gsa_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .valid_o (valid_o),
    .result_o(result_o)
  );
endmodule
`default_nettype wire

// ===== tb/tb_generational_slot_allocator.sv =====
// Self-checking testbench for the generational slot allocator.
`timescale 1ns / 1ps
module tb_generational_slot_allocator;
  import gsa_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_item_t  item_i;
  logic      valid_o;
  out_item_t result_o;

  generational_slot_allocator i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  // The clock runs with a period of 4 ns.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Shadow copy of the allocator state, kept in step with each accepted item.
  logic        sh_used [Slots];
  logic [31:0] sh_gen [Slots];
  logic [31:0] sh_counter;
  int unsigned sh_length;
  logic [3:0]  sh_free [Slots];
  int unsigned sh_free_n;
  logic [3:0]  sh_pend [Slots];
  int unsigned sh_pend_n;
  int unsigned sh_depth;

  // Results that the allocator still owes, oldest first.
  out_item_t owed_results[$];
  int        fail_count;
  int        cycle_count;

  function automatic out_item_t make_result(logic kind, logic [3:0] idx, logic [31:0] gen,
                                            status_e st, logic act, logic lst);
    out_item_t r;
    r.kind = kind;
    r.out_index = idx;
    r.out_generation = gen;
    r.status = st;
    r.active = act;
    r.last = lst;
    return r;
  endfunction

  // Appends one result to the back of the owed queue.
  function automatic void owe_result(out_item_t r);
    owed_results.insert(owed_results.size(), r);
  endfunction

  function automatic logic [31:0] take_gen();
    logic [31:0] g;
    g = sh_counter;
    sh_counter = sh_counter + 32'd1;
    if (sh_counter == 32'd0) begin
      sh_counter = 32'd1;
    end
    return g;
  endfunction

  function automatic void push_free_slot(logic [3:0] idx);
    if (sh_free_n < Slots) begin
      sh_free[sh_free_n] = idx;
      sh_free_n++;
    end
  endfunction

  function automatic void trim_tail();
    while (sh_length > 0 && !sh_used[sh_length-1]) begin
      sh_length--;
    end
  endfunction

  function automatic logic is_live(logic [3:0] idx, logic [31:0] gen);
    return (idx < sh_length) && sh_used[idx] && (sh_gen[idx] == gen);
  endfunction

  // Works out every result an item causes and queues them behind the others.
  function automatic void predict_results(in_item_t it);
    logic       found;
    logic [3:0] slot;
    found = 1'b0;
    slot = '0;
    case (op_e'(it.operation))
      OP_INSERT: begin
        if (sh_depth == 0) begin
          while (sh_free_n > 0 && !found) begin
            sh_free_n--;
            slot = sh_free[sh_free_n];
            if (slot < sh_length && !sh_used[slot]) begin
              found = 1'b1;
            end
          end
        end
        if (!found && sh_length >= Slots) begin
          owe_result(make_result(1'b0, '0, '0, ST_FULL, 1'b0, 1'b1));
        end else begin
          if (!found) begin
            slot = sh_length[3:0];
            sh_length++;
          end
          sh_used[slot] = 1'b1;
          sh_gen[slot] = take_gen();
          owe_result(make_result(1'b0, slot, sh_gen[slot], ST_OK, 1'b0, 1'b1));
        end
      end
      OP_CLOSE: begin
        if (!is_live(it.slot_index, it.handle_generation)) begin
          owe_result(make_result(1'b0, '0, '0, ST_STALE, 1'b0, 1'b1));
        end else begin
          sh_used[it.slot_index] = 1'b0;
          sh_gen[it.slot_index] = take_gen();
          if (sh_depth != 0) begin
            if (sh_pend_n < Slots) begin
              sh_pend[sh_pend_n] = it.slot_index;
              sh_pend_n++;
            end
          end else begin
            owe_result(make_result(1'b1, it.slot_index, '0, ST_OK, 1'b0, 1'b0));
            push_free_slot(it.slot_index);
            trim_tail();
          end
          owe_result(make_result(1'b0, '0, '0, ST_OK, 1'b0, 1'b1));
        end
      end
      OP_QUERY: begin
        owe_result(make_result(1'b0, '0, '0, ST_OK,
                               is_live(it.slot_index, it.handle_generation), 1'b1));
      end
      OP_ENTER: begin
        if (sh_depth >= MaxDepth) begin
          owe_result(make_result(1'b0, '0, '0, ST_NEST, 1'b0, 1'b1));
        end else begin
          sh_depth++;
          owe_result(make_result(1'b0, '0, '0, ST_OK, 1'b0, 1'b1));
        end
      end
      OP_EXIT: begin
        if (sh_depth == 0) begin
          owe_result(make_result(1'b0, '0, '0, ST_NEST, 1'b0, 1'b1));
        end else begin
          sh_depth--;
          if (sh_depth == 0) begin
            for (int i = 0; i < sh_pend_n; i++) begin
              owe_result(make_result(1'b1, sh_pend[i], '0, ST_OK, 1'b0, 1'b0));
            end
            for (int i = 0; i < sh_pend_n; i++) begin
              if (sh_pend[i] < sh_length && !sh_used[sh_pend[i]]) begin
                push_free_slot(sh_pend[i]);
              end
            end
            sh_pend_n = 0;
            trim_tail();
          end
          owe_result(make_result(1'b0, '0, '0, ST_OK, 1'b0, 1'b1));
        end
      end
      OP_DESTROY: begin
        for (int i = 0; i < sh_length; i++) begin
          if (sh_used[i]) begin
            owe_result(make_result(1'b1, i[3:0], '0, ST_OK, 1'b0, 1'b0));
          end
        end
        for (int i = 0; i < sh_pend_n; i++) begin
          owe_result(make_result(1'b1, sh_pend[i], '0, ST_OK, 1'b0, 1'b0));
        end
        for (int i = 0; i < Slots; i++) begin
          sh_used[i] = 1'b0;
        end
        sh_length = 0;
        sh_free_n = 0;
        sh_pend_n = 0;
        sh_depth = 0;
        owe_result(make_result(1'b0, '0, '0, ST_OK, 1'b0, 1'b1));
      end
      default: begin
        owe_result(make_result(1'b0, '0, '0, ST_STALE, 1'b0, 1'b1));
      end
    endcase
  endfunction

  // Results cannot be held off, so each one is checked on the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result_o);
        fail_count++;
      end else begin
        out_item_t w;
        w = owed_results.pop_front();
        if (result_o !== w) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, w, result_o);
          fail_count++;
        end
      end
    end
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 200000) begin
      $display("FAIL");
      $finish;
    end
  end

  // A directed row; a typed-in result applies only where has_result is set.
  typedef struct {
    op_e         op;
    logic [3:0]  idx;
    logic [31:0] gen;
    logic        has_result;
    out_item_t   result;
  } step_t;

  step_t directed[$];

  // A random gap before each item, mostly short and now and then long.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 : (($urandom_range(0, 9) < 8) ?
        $urandom_range(1, 3) : $urandom_range(8, 40));
    if (n > 0) begin
      start <= 1'b0;
    end
    repeat (n) @(posedge clk_i);
  endtask

  // Presents one item and waits for the edge that accepts it.
  task automatic send_item(in_item_t it);
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    predict_results(it);
  endtask

  task automatic add_row(op_e op, logic [3:0] idx, logic [31:0] gen, logic has,
                         out_item_t r);
    step_t s;
    s.op = op;
    s.idx = idx;
    s.gen = gen;
    s.has_result = has;
    s.result = r;
    directed.insert(directed.size(), s);
  endtask

  // A random item of any operation, with a handle that is usually live, sometimes stale or made up.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    int       r;
    pick = $urandom_range(0, 99);
    it.slot_index = 4'($urandom);
    it.handle_generation = $urandom;
    if (pick < 35) begin
      it.operation = OP_INSERT;
    end else if (pick < 60) begin
      it.operation = OP_CLOSE;
    end else if (pick < 75) begin
      it.operation = OP_QUERY;
    end else if (pick < 83) begin
      it.operation = OP_ENTER;
    end else if (pick < 92) begin
      it.operation = OP_EXIT;
    end else if (pick < 95) begin
      it.operation = OP_DESTROY;
    end else begin
      it.operation = $urandom_range(0, 1) ? OP_BAD6 : OP_BAD7;
    end
    r = $urandom_range(0, 9);
    if (r < 7 && sh_length > 0) begin
      it.slot_index = 4'($urandom_range(0, sh_length - 1));
      it.handle_generation = sh_gen[it.slot_index];
    end else if (r < 9) begin
      it.handle_generation = sh_counter - 32'($urandom_range(1, 20));
    end
    return it;
  endfunction

  initial begin
    in_item_t  it;
    out_item_t none;
    none = '0;
    fail_count = 0;
    cycle_count = 0;
    start = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      sh_used[i] = 1'b0;
      sh_gen[i] = '0;
    end
    sh_counter = 32'd1;
    sh_length = 0;
    sh_free_n = 0;
    sh_pend_n = 0;
    sh_depth = 0;

    // Directed rows: errors on an empty table, inserts, live and stale handles,
    // nesting with a parked close, extreme field values and undefined codes.
    add_row(OP_EXIT, 4'd0, 32'd0, 1'b1, make_result(1'b0, '0, '0, ST_NEST, 1'b0, 1'b1));
    add_row(OP_CLOSE, 4'd0, 32'd0, 1'b1, make_result(1'b0, '0, '0, ST_STALE, 1'b0, 1'b1));
    add_row(OP_QUERY, 4'd15, 32'hFFFF_FFFF, 1'b1,
            make_result(1'b0, '0, '0, ST_OK, 1'b0, 1'b1));
    add_row(OP_INSERT, 4'd0, 32'd0, 1'b1, make_result(1'b0, 4'd0, 32'd1, ST_OK, 1'b0, 1'b1));
    add_row(OP_INSERT, 4'd15, 32'hFFFF_FFFF, 1'b1,
            make_result(1'b0, 4'd1, 32'd2, ST_OK, 1'b0, 1'b1));
    add_row(OP_QUERY, 4'd1, 32'd2, 1'b1, make_result(1'b0, '0, '0, ST_OK, 1'b1, 1'b1));
    add_row(OP_CLOSE, 4'd0, 32'd1, 1'b0, none);
    add_row(OP_CLOSE, 4'd0, 32'd1, 1'b1, make_result(1'b0, '0, '0, ST_STALE, 1'b0, 1'b1));
    add_row(OP_INSERT, 4'd0, 32'd0, 1'b0, none);
    add_row(OP_ENTER, 4'd0, 32'd0, 1'b0, none);
    add_row(OP_CLOSE, 4'd1, 32'd2, 1'b0, none);
    add_row(OP_INSERT, 4'd0, 32'd0, 1'b0, none);
    add_row(OP_EXIT, 4'd0, 32'd0, 1'b0, none);
    add_row(OP_BAD6, 4'd7, 32'h5555_5555, 1'b1,
            make_result(1'b0, '0, '0, ST_STALE, 1'b0, 1'b1));
    add_row(OP_BAD7, 4'd8, 32'hAAAA_AAAA, 1'b1,
            make_result(1'b0, '0, '0, ST_STALE, 1'b0, 1'b1));
    add_row(OP_DESTROY, 4'd0, 32'd0, 1'b0, none);
    add_row(OP_QUERY, 4'd0, 32'd5, 1'b1, make_result(1'b0, '0, '0, ST_OK, 1'b0, 1'b1));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      it.operation = directed[k].op;
      it.slot_index = directed[k].idx;
      it.handle_generation = directed[k].gen;
      idle_gap();
      send_item(it);
      // Typed-in rows are also held against the shadow, so a slip shows either way.
      if (directed[k].has_result && owed_results[$] !== directed[k].result) begin
        $display("%0t: row %0d, expected %p, predicted %p", $time, k,
                 directed[k].result, owed_results[$]);
        fail_count++;
      end
    end

    // Fill the table to the brim, push the nesting depth to its ceiling, park every
    // slot on the pending list, leave two guards, then drop it all with destroy all.
    repeat (Slots + 1) begin
      it = '0;
      it.operation = OP_INSERT;
      send_item(it);
    end
    repeat (256) begin
      it = '0;
      it.operation = OP_ENTER;
      send_item(it);
    end
    for (int i = 0; i < Slots; i++) begin
      it.operation = OP_CLOSE;
      it.slot_index = i[3:0];
      it.handle_generation = sh_gen[i];
      send_item(it);
    end
    repeat (2) begin
      it = '0;
      it.operation = OP_EXIT;
      send_item(it);
    end
    it = '0;
    it.operation = OP_DESTROY;
    send_item(it);

    // Random items, with bursts of gaps and stretches without any.
    for (int n = 0; n < 100; n++) begin
      if ((n / 50) % 2 == 0) begin
        idle_gap();
      end
      send_item(random_item());
    end
    start <= 1'b0;

    while (owed_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (60) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
